[rtl/tnc_pkg.sv]
// Shared widths, constants and operation codes for the tick/nanosecond converter.
`default_nettype none

package tnc_pkg;

  localparam int unsigned VAL_W   = 64;              // signed time value
  localparam int unsigned HZ_W    = 34;              // clock_hz register
  localparam int unsigned HALF_W  = VAL_W / 2;       // magnitude split for partial products
  localparam int unsigned PP_W    = HALF_W + HZ_W;   // one partial product
  localparam int unsigned PROD_W  = VAL_W + HZ_W;    // full magnitude product
  localparam int unsigned Q_W     = VAL_W - 1;       // quotient bits below the overflow limit

  localparam logic [HZ_W-1:0]  NS_PER_SEC     = HZ_W'(64'd1000000000);
  localparam logic [HZ_W-1:0]  CLOCK_HZ_RESET = HZ_W'(64'd1000000000);
  localparam logic [VAL_W-1:0] POS_MAX        = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MAX        = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

  typedef enum logic {
    OP_TICKS_TO_NS = 1'b0,
    OP_NS_TO_TICKS = 1'b1
  } op_t;

endpackage

`default_nettype wire

[rtl/tick_nanosecond_converter_core.sv]
// Pipelined signed tick/nanosecond converter: 98-bit product, restoring division.
//
// Usage:
//   Input stream: in_tdata carries the signed 64-bit time value, in_tuser the
//   operation (0: ticks to ns, value*1e9/clock_hz; 1: ns to ticks,
//   value*clock_hz/1e9). Result stream: out_tdata is the signed result,
//   truncated toward zero; out_tuser is the overflow flag, set when the
//   quotient magnitude passes 2^63-1 and the result saturates to +/-(2^63-1).
//   cfg_data writes clock_hz; write it only while no transaction is in flight.
//   Depth: 68 register stages, from the input register to the output register.
//   Throughput: one transaction per cycle. The depth comes from the divider,
//   which retires one quotient bit per stage over 63 stages, after an input
//   register, a split 64x34 multiply, a product add and an overflow compare.
//   A stalled receiver fills a one-entry skid buffer behind the output
//   register; only then does in_tready drop and the whole pipeline hold.
//   Reset clears all valid bits, empties the skid buffer and loads clock_hz
//   with 1e9.
`default_nettype none

module tick_nanosecond_converter_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [tnc_pkg::VAL_W-1:0]   in_tdata,   // [63:0] value
  input  wire logic                        in_tuser,   // [0] op
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [tnc_pkg::VAL_W-1:0]        out_tdata,  // [63:0] result
  output logic                             out_tuser,  // [0] overflow
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tnc_pkg::HZ_W-1:0]    cfg_data    // [33:0] clock_hz
);
  import tnc_pkg::*;

  localparam int unsigned DIV_STEPS = Q_W;

  function automatic logic [HZ_W-1:0] pick_divisor(input op_t op, input logic [HZ_W-1:0] hz);
    return (op == OP_NS_TO_TICKS) ? NS_PER_SEC : hz;
  endfunction

  function automatic logic [HZ_W-1:0] pick_mult(input op_t op, input logic [HZ_W-1:0] hz);
    return (op == OP_NS_TO_TICKS) ? hz : NS_PER_SEC;
  endfunction

  logic [HZ_W-1:0] clock_hz_r;
  logic            run;

  // stage A: sign and magnitude
  logic             a_valid_r;
  op_t              a_op_r;
  logic             a_neg_r;
  logic [VAL_W-1:0] a_mag_r;

  // stage B: partial products
  logic            b_valid_r;
  op_t             b_op_r;
  logic            b_neg_r;
  logic [PP_W-1:0] b_pp_lo_r;
  logic [PP_W-1:0] b_pp_hi_r;

  // stage C: full product
  logic              c_valid_r;
  op_t               c_op_r;
  logic              c_neg_r;
  logic [PROD_W-1:0] c_prod_r;

  // divider stages; index 0 is the overflow-compare stage
  logic           dv_valid_r [0:DIV_STEPS];
  op_t            dv_op_r    [0:DIV_STEPS];
  logic           dv_neg_r   [0:DIV_STEPS];
  logic           dv_ovf_r   [0:DIV_STEPS];
  logic [HZ_W-1:0] dv_rem_r  [0:DIV_STEPS];
  logic [Q_W-1:0]  dv_w_r    [0:DIV_STEPS];

  // output register and skid buffer
  logic             out_valid_r;
  logic [VAL_W-1:0] out_data_r;
  logic             out_ovf_r;
  logic             skid_valid_r;
  logic [VAL_W-1:0] skid_data_r;
  logic             skid_ovf_r;

  logic [HZ_W:0]    ovf_hi;
  logic [HZ_W:0]    ovf_dsor;
  logic             ovf_hit;
  logic [VAL_W-1:0] tail_q;
  logic [VAL_W-1:0] tail_result;
  logic             tail_go;
  logic             slot_free;

  assign run       = !skid_valid_r;
  assign in_tready = run;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RESET;
    end else if (cfg_valid) begin
      clock_hz_r <= cfg_data;
    end
  end

  // front stages: valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      c_valid_r     <= 1'b0;
      dv_valid_r[0] <= 1'b0;
    end else if (run) begin
      a_valid_r     <= in_tvalid;
      b_valid_r     <= a_valid_r;
      c_valid_r     <= b_valid_r;
      dv_valid_r[0] <= c_valid_r;
    end
  end

  always_comb begin
    ovf_hi   = c_prod_r[PROD_W-1:Q_W];
    ovf_dsor = {1'b0, pick_divisor(c_op_r, clock_hz_r)};
    // quotient reaches 2^63 exactly when the top product bits reach the divisor
    ovf_hit  = ovf_hi >= ovf_dsor;
  end

  // front stages: payload
  always_ff @(posedge clk) begin
    if (run) begin
      a_op_r    <= op_t'(in_tuser);
      a_neg_r   <= in_tdata[VAL_W-1];
      a_mag_r   <= in_tdata[VAL_W-1] ? (~in_tdata + VAL_W'(1)) : in_tdata;

      b_op_r    <= a_op_r;
      b_neg_r   <= a_neg_r;
      b_pp_lo_r <= PP_W'(a_mag_r[HALF_W-1:0]) * PP_W'(pick_mult(a_op_r, clock_hz_r));
      b_pp_hi_r <= PP_W'(a_mag_r[VAL_W-1:HALF_W]) * PP_W'(pick_mult(a_op_r, clock_hz_r));

      c_op_r    <= b_op_r;
      c_neg_r   <= b_neg_r;
      c_prod_r  <= PROD_W'(b_pp_lo_r) + {b_pp_hi_r, {HALF_W{1'b0}}};

      dv_op_r[0]  <= c_op_r;
      dv_neg_r[0] <= c_neg_r;
      dv_ovf_r[0] <= ovf_hit;
      dv_rem_r[0] <= ovf_hit ? '0 : ovf_hi[HZ_W-1:0];
      dv_w_r[0]   <= c_prod_r[Q_W-1:0];
    end
  end

  // one quotient bit per stage: shift product bits out the top, quotient bits in the bottom
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [HZ_W:0] trial;
    logic [HZ_W:0] dsor;
    logic          take;

    always_comb begin
      dsor  = {1'b0, pick_divisor(dv_op_r[k], clock_hz_r)};
      trial = {dv_rem_r[k], dv_w_r[k][Q_W-1]};
      take  = trial >= dsor;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (run) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (run) begin
        dv_op_r[k+1]  <= dv_op_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_ovf_r[k+1] <= dv_ovf_r[k];
        dv_rem_r[k+1] <= take ? HZ_W'(trial - dsor) : trial[HZ_W-1:0];
        dv_w_r[k+1]   <= {dv_w_r[k][Q_W-2:0], take};
      end
    end
  end

  // saturate, then restore the sign
  always_comb begin
    tail_q      = dv_ovf_r[DIV_STEPS] ? POS_MAX : {1'b0, dv_w_r[DIV_STEPS]};
    tail_result = dv_neg_r[DIV_STEPS] ? (~tail_q + VAL_W'(1)) : tail_q;
    tail_go     = run && dv_valid_r[DIV_STEPS];
    slot_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r  <= skid_valid_r || tail_go;
      skid_valid_r <= 1'b0;
    end else if (tail_go) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : tail_result;
      out_ovf_r  <= skid_valid_r ? skid_ovf_r  : dv_ovf_r[DIV_STEPS];
    end else if (tail_go) begin
      skid_data_r <= tail_result;
      skid_ovf_r  <= dv_ovf_r[DIV_STEPS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds a transaction while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid buffer filled without a stalled output");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == POS_MAX || out_tdata == NEG_MAX))
    else $error("overflow flagged without a saturated result");

  a_no_min_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != {1'b1, {(VAL_W-1){1'b0}}}))
    else $error("result reached the most negative value");

  a_div_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r[DIV_STEPS] && !dv_ovf_r[DIV_STEPS])
      |-> (dv_rem_r[DIV_STEPS] < pick_divisor(dv_op_r[DIV_STEPS], clock_hz_r)))
    else $error("final division remainder not below divisor");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Stream testbench for the tick/nanosecond converter with a self-checking scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import tnc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_ITEMS    = 148;
  localparam int MAX_PRINTED    = 40;

  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [HZ_W-1:0]  HZ_MAX  = {HZ_W{1'b1}};

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [VAL_W-1:0] result;
    logic             overflow;
  } conv_t;

  class time_conv_board;
    logic [HZ_W-1:0] clock_hz;
    conv_t           expected_conv_q[$];
    int              errors;

    function new();
      clock_hz = CLOCK_HZ_RESET;
      errors   = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    // Magnitude times multiplier, divided, saturated, then the sign restored.
    function void predict_conversion(input op_t op, input logic [VAL_W-1:0] value);
      logic              neg;
      logic [VAL_W-1:0]  mag;
      logic [VAL_W-1:0]  sat;
      logic [HZ_W-1:0]   mult;
      logic [HZ_W-1:0]   divisor;
      logic [127:0]      product;
      logic [127:0]      quotient;
      conv_t             conv;
      neg      = value[VAL_W-1];
      mag      = neg ? -value : value;
      mult     = (op == OP_NS_TO_TICKS) ? clock_hz : NS_PER_SEC;
      divisor  = (op == OP_NS_TO_TICKS) ? NS_PER_SEC : clock_hz;
      product  = {64'd0, mag} * {94'd0, mult};
      quotient = '1;
      if (divisor != '0) begin
        quotient = product / {94'd0, divisor};
      end
      conv.overflow = (quotient > {64'd0, POS_MAX});
      sat           = conv.overflow ? POS_MAX : quotient[VAL_W-1:0];
      conv.result   = neg ? -sat : sat;
      expected_conv_q.push_back(conv);
    endfunction

    task check_conversion(input logic [VAL_W-1:0] result, input logic overflow);
      conv_t want;
      if (expected_conv_q.size() == 0) begin
        report($sformatf("result %h ovf %b with no transaction pending", result, overflow));
        return;
      end
      want = expected_conv_q.pop_front();
      if (result !== want.result) begin
        report($sformatf("result %h, expected %h", result, want.result));
      end
      if (overflow !== want.overflow) begin
        report($sformatf("overflow %b, expected %b (result %h)", overflow, want.overflow,
                         want.result));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata   = '0;   // [63:0] value
  logic             in_tuser   = 1'b0; // [0] op
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [VAL_W-1:0] out_tdata;         // [63:0] result
  logic             out_tuser;         // [0] overflow
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [HZ_W-1:0]  cfg_data   = '0;   // [33:0] clock_hz

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int idle_cycles  = 0;

  time_conv_board board = new();

  tick_nanosecond_converter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_conversion(out_tdata, out_tuser);
    end
  end

  // Restart the count on any transaction; give up once the block goes quiet.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tick_nanosecond_converter_core verification failed");
      $finish;
    end
  end

  task automatic set_idle_mode(input idle_mode_t mode);
    tx_idle_pct  = (mode == IDLE_SENDER) ? 48 : (mode == IDLE_BOTH) ? 11 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 48 : (mode == IDLE_BOTH) ? 11 : 0;
  endtask

  task automatic send_conv(input op_t op, input logic [VAL_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    board.predict_conversion(op, value);
  endtask

  // Drop valid, then hold until every pending result is back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_conv_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_clock_hz(input logic [HZ_W-1:0] hz);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.clock_hz = hz;
  endtask

  // Spread magnitudes over all scales so the overflow boundary is crossed from both sides.
  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       v = POS_MAX;
      1:       v = NEG_MIN;
      2:       v = NEG_MIN + 1;
      3:       v = '0;
      4:       v = v >> $urandom_range(40, 63);
      default: v = v >> $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic run_random(input int n, input bit pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) begin
        drain_results();
      end
      send_conv(op_t'($urandom_range(0, 1)), random_value());
    end
  endtask

  initial begin
    logic [VAL_W-1:0] corner_vals [6];
    logic [HZ_W-1:0]  phase_hz [9];
    corner_vals = '{64'd0, 64'd1, POS_MAX, NEG_MIN, NEG_MIN + 1, -64'd999_999_999};
    phase_hz    = '{34'd1, HZ_MAX, 34'd0, 34'd32768, 34'd25_000_000,
                    {2'($urandom_range(0, 3)), $urandom}, 34'd3_000_000_000,
                    34'($urandom_range(2, 5000)), CLOCK_HZ_RESET};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset rate both conversions are the identity, but NEG_MIN saturates to -(2^63-1).
    foreach (corner_vals[k]) begin
      send_conv(OP_TICKS_TO_NS, corner_vals[k]);
      send_conv(OP_NS_TO_TICKS, corner_vals[k]);
    end

    // Zero rate: ticks to ns saturates on any input, zero included; ns to ticks returns zero.
    write_clock_hz('0);
    send_conv(OP_TICKS_TO_NS, 64'd0);
    send_conv(OP_TICKS_TO_NS, 64'd1);
    send_conv(OP_TICKS_TO_NS, -64'd1);
    send_conv(OP_TICKS_TO_NS, NEG_MIN);
    send_conv(OP_NS_TO_TICKS, 64'd0);
    send_conv(OP_NS_TO_TICKS, NEG_MIN);

    // One tick per second: overflow begins just above 9223372036 ticks.
    write_clock_hz(34'd1);
    send_conv(OP_TICKS_TO_NS, 64'd9_223_372_036);
    send_conv(OP_TICKS_TO_NS, -64'd9_223_372_037);
    send_conv(OP_NS_TO_TICKS, POS_MAX);
    send_conv(OP_NS_TO_TICKS, -64'd999_999_999);

    write_clock_hz(HZ_MAX);
    send_conv(OP_NS_TO_TICKS, POS_MAX);
    send_conv(OP_NS_TO_TICKS, -64'd1);

    write_clock_hz(CLOCK_HZ_RESET);
    set_idle_mode(IDLE_NONE);
    run_random(PHASE_ITEMS, 1'b0);

    foreach (phase_hz[p]) begin
      write_clock_hz(phase_hz[p]);
      set_idle_mode(idle_mode_t'((p + 1) % 4));
      run_random(PHASE_ITEMS, p == 0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tick_nanosecond_converter_core verification clean");
    end else begin
      $display("tick_nanosecond_converter_core verification failed");
    end
    $finish;
  end

endmodule
